FILE: rtl/jbt_pkg.sv
// Shared types, constants and helper functions for the JSON byte tokenizer.
// No dependencies; imported by every module and by the testbench.
package jbt_pkg;

  // Widths of the position counters and of the reported result fields.
  localparam int LINE_BITS    = 16;
  localparam int COLUMN_BITS  = 16;
  localparam int FIELD_BITS   = 16;
  localparam int RES_DEPTH    = 4;
  localparam int RES_PTR_BITS = $clog2(RES_DEPTH);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_KEYWORD,
    MODE_STRING,
    MODE_ESCAPE,
    MODE_NUMBER
  } lex_mode_t;

  typedef enum logic [1:0] {
    KW_TRUE,
    KW_FALSE,
    KW_NULL
  } keyword_t;

  typedef enum logic [3:0] {
    KIND_LBRACE,
    KIND_RBRACE,
    KIND_LBRACKET,
    KIND_RBRACKET,
    KIND_COLON,
    KIND_COMMA,
    KIND_TRUE,
    KIND_FALSE,
    KIND_NULL,
    KIND_STRING,
    KIND_NUMBER,
    KIND_END,
    KIND_ERROR
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_UNEXPECTED,
    ERR_UNTERMINATED
  } error_code_t;

  // One result as it travels from the lexer through the result queue.
  typedef struct packed {
    token_kind_t             kind;
    logic [FIELD_BITS-1:0]   line;
    logic [FIELD_BITS-1:0]   column;
    logic [FIELD_BITS-1:0]   length;
    error_code_t             err;
    logic                    last;
  } jbt_result_t;

  // Expected character of a keyword at a given position; zero past its end.
  function automatic logic [7:0] kw_char(keyword_t id, logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (id)
      KW_TRUE: begin
        case (pos)
          3'd0:    c = "t";
          3'd1:    c = "r";
          3'd2:    c = "u";
          3'd3:    c = "e";
          default: c = 8'h00;
        endcase
      end
      KW_FALSE: begin
        case (pos)
          3'd0:    c = "f";
          3'd1:    c = "a";
          3'd2:    c = "l";
          3'd3:    c = "s";
          3'd4:    c = "e";
          default: c = 8'h00;
        endcase
      end
      KW_NULL: begin
        case (pos)
          3'd0:    c = "n";
          3'd1:    c = "u";
          3'd2:    c = "l";
          3'd3:    c = "l";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Number of characters in a keyword.
  function automatic logic [2:0] kw_size(keyword_t id);
    logic [2:0] s;
    case (id)
      KW_FALSE: s = 3'd5;
      default:  s = 3'd4;
    endcase
    return s;
  endfunction

  // Clamp a line count to the reported field width.
  function automatic logic [FIELD_BITS-1:0] clamp_line(logic [LINE_BITS-1:0] v);
    logic [LINE_BITS+FIELD_BITS-1:0] w;
    logic [FIELD_BITS-1:0]           r;
    w = {{FIELD_BITS{1'b0}}, v};
    if (w > {{LINE_BITS{1'b0}}, {FIELD_BITS{1'b1}}}) begin
      r = '1;
    end else begin
      r = w[FIELD_BITS-1:0];
    end
    return r;
  endfunction

  // Clamp a column to the reported field width.
  function automatic logic [FIELD_BITS-1:0] clamp_col(logic [COLUMN_BITS-1:0] v);
    logic [COLUMN_BITS+FIELD_BITS-1:0] w;
    logic [FIELD_BITS-1:0]             r;
    w = {{FIELD_BITS{1'b0}}, v};
    if (w > {{COLUMN_BITS{1'b0}}, {FIELD_BITS{1'b1}}}) begin
      r = '1;
    end else begin
      r = w[FIELD_BITS-1:0];
    end
    return r;
  endfunction

  // Build a result with the last-of-run flag cleared.
  function automatic jbt_result_t mk_result(token_kind_t kind,
                                            logic [FIELD_BITS-1:0] line,
                                            logic [FIELD_BITS-1:0] column,
                                            logic [FIELD_BITS-1:0] length,
                                            error_code_t err);
    jbt_result_t r;
    r.kind   = kind;
    r.line   = line;
    r.column = column;
    r.length = length;
    r.err    = err;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/jbt_text_if.sv
// Request channel carrying one byte of document text per request.
// Depends on nothing; used by the tokenizer top level.
interface jbt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_document;

  modport source (output valid, output text_byte, output end_of_document, input ready);
  modport sink   (input valid, input text_byte, input end_of_document, output ready);
endinterface

FILE: rtl/jbt_token_if.sv
// Request channel carrying one token result per request.
// Depends on nothing; used by the tokenizer top level.
interface jbt_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [15:0] token_length;
  logic [1:0]  error_code;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_line, output start_column,
                  output token_length, output error_code, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_line, input start_column,
                  input token_length, input error_code, input last_of_run, output ready);
endinterface

FILE: rtl/jbt_lexer.sv
// Lexer state registers and the single-pass next-state and result logic.
// Depends on jbt_pkg; produces up to two results for each byte it consumes.
module jbt_lexer (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          text_byte,
  input  logic                end_of_document,
  output jbt_pkg::jbt_result_t res0,
  output jbt_pkg::jbt_result_t res1,
  output logic [1:0]          res_count
);
  import jbt_pkg::*;

  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [2:0] POS_LIMIT    = 3'd5;

  lex_mode_t               lex_mode, lex_mode_next;
  keyword_t                keyword_id, keyword_id_next;
  logic [2:0]              match_position, match_position_next;
  logic [COLUMN_BITS-1:0]  token_start_column, token_start_column_next;
  logic [LINE_BITS-1:0]    line_counter, line_counter_next;
  logic [COLUMN_BITS-1:0]  column_counter, column_counter_next;
  logic                    error_latched, error_latched_next;
  logic [FIELD_BITS-1:0]   tok_len, tok_len_next;

  logic [FIELD_BITS-1:0]   len_inc;
  logic [COLUMN_BITS-1:0]  col_inc;
  logic [LINE_BITS-1:0]    line_inc;
  logic [2:0]              pos_clamped;
  logic [2:0]              pos_inc;
  logic                    kw_match;
  logic                    is_digit;
  logic                    close_v;
  jbt_result_t             close_res;
  logic                    close_err;
  logic                    e0_v, e1_v;
  jbt_result_t             e0, e1;

  // Saturating increments and keyword comparison.
  assign len_inc     = (tok_len != '1) ? tok_len + 1'b1 : tok_len;
  assign col_inc     = (column_counter != '1) ? column_counter + 1'b1 : column_counter;
  assign line_inc    = (line_counter != '1) ? line_counter + 1'b1 : line_counter;
  assign pos_clamped = (match_position > POS_LIMIT) ? POS_LIMIT : match_position;
  assign pos_inc     = pos_clamped + 3'd1;
  assign kw_match    = (kw_char(keyword_id, pos_clamped) == text_byte) &&
                       (pos_clamped < kw_size(keyword_id));
  assign is_digit    = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);

  // What a line end or end of document does to a pending token.
  always_comb begin
    close_v   = 1'b0;
    close_err = 1'b0;
    close_res = mk_result(KIND_NUMBER, clamp_line(line_counter),
                          clamp_col(token_start_column), tok_len, ERR_NONE);
    case (lex_mode)
      MODE_NUMBER: begin
        close_v = 1'b1;
      end
      MODE_STRING, MODE_ESCAPE: begin
        close_v   = 1'b1;
        close_err = 1'b1;
        close_res = mk_result(KIND_ERROR, clamp_line(line_counter),
                              clamp_col(column_counter), tok_len, ERR_UNTERMINATED);
      end
      MODE_KEYWORD: begin
        close_v   = 1'b1;
        close_err = 1'b1;
        close_res = mk_result(KIND_ERROR, clamp_line(line_counter),
                              clamp_col(token_start_column), FIELD_BITS'(1), ERR_UNEXPECTED);
      end
      default: begin
        close_v = 1'b0;
      end
    endcase
  end

  // Next state and up to two results for the byte in the input register.
  always_comb begin
    lex_mode_next           = lex_mode;
    keyword_id_next         = keyword_id;
    match_position_next     = match_position;
    token_start_column_next = token_start_column;
    line_counter_next       = line_counter;
    column_counter_next     = column_counter;
    error_latched_next      = error_latched;
    tok_len_next            = tok_len;
    e0_v = 1'b0;
    e1_v = 1'b0;
    e0   = close_res;
    e1   = close_res;

    if (end_of_document) begin
      // Close what is pending, report the line count, then return to reset.
      e0_v = close_v && !error_latched;
      e1_v = 1'b1;
      e1   = mk_result(KIND_END, clamp_line(line_inc), '0, '0, ERR_NONE);
      lex_mode_next           = MODE_IDLE;
      keyword_id_next         = KW_TRUE;
      match_position_next     = '0;
      token_start_column_next = '0;
      line_counter_next       = '0;
      column_counter_next     = '0;
      error_latched_next      = 1'b0;
      tok_len_next            = '0;
    end else if (error_latched) begin
      // Everything is dropped until the document ends.
      e0_v = 1'b0;
    end else if (text_byte == CH_LF) begin
      e0_v                = close_v;
      error_latched_next  = close_err;
      lex_mode_next       = MODE_IDLE;
      line_counter_next   = line_inc;
      column_counter_next = '0;
    end else begin
      column_counter_next = col_inc;
      case (lex_mode)
        MODE_KEYWORD: begin
          match_position_next = '0;
          lex_mode_next       = MODE_IDLE;
          if (kw_match) begin
            if (pos_inc >= kw_size(keyword_id)) begin
              e0_v = 1'b1;
              e0   = mk_result(token_kind_t'(4'(KIND_TRUE) + 4'(keyword_id)),
                               clamp_line(line_counter), clamp_col(token_start_column),
                               FIELD_BITS'(kw_size(keyword_id)), ERR_NONE);
            end else begin
              match_position_next = pos_inc;
              lex_mode_next       = MODE_KEYWORD;
            end
          end else begin
            e0_v = 1'b1;
            e0   = mk_result(KIND_ERROR, clamp_line(line_counter),
                             clamp_col(token_start_column), FIELD_BITS'(1), ERR_UNEXPECTED);
            error_latched_next = 1'b1;
          end
        end
        MODE_STRING: begin
          tok_len_next = len_inc;
          if (text_byte == CH_BACKSLASH) begin
            lex_mode_next = MODE_ESCAPE;
          end else if (text_byte == CH_QUOTE) begin
            e0_v = 1'b1;
            e0   = mk_result(KIND_STRING, clamp_line(line_counter),
                             clamp_col(token_start_column), len_inc, ERR_NONE);
            lex_mode_next = MODE_IDLE;
          end
        end
        MODE_ESCAPE: begin
          tok_len_next  = len_inc;
          lex_mode_next = MODE_STRING;
        end
        default: begin
          if ((lex_mode == MODE_NUMBER) && is_digit) begin
            tok_len_next = len_inc;
          end else begin
            // A number ends here; the byte itself is then lexed from idle.
            e0_v          = (lex_mode == MODE_NUMBER);
            lex_mode_next = MODE_IDLE;
            e1 = mk_result(KIND_LBRACE, clamp_line(line_counter),
                           clamp_col(column_counter), FIELD_BITS'(1), ERR_NONE);
            case (text_byte)
              CH_SPACE, CH_TAB, CH_CR: begin
                e1_v = 1'b0;
              end
              "{": begin
                e1_v = 1'b1;
              end
              "}": begin
                e1_v    = 1'b1;
                e1.kind = KIND_RBRACE;
              end
              "[": begin
                e1_v    = 1'b1;
                e1.kind = KIND_LBRACKET;
              end
              "]": begin
                e1_v    = 1'b1;
                e1.kind = KIND_RBRACKET;
              end
              ":": begin
                e1_v    = 1'b1;
                e1.kind = KIND_COLON;
              end
              ",": begin
                e1_v    = 1'b1;
                e1.kind = KIND_COMMA;
              end
              "t", "f", "n": begin
                lex_mode_next           = MODE_KEYWORD;
                keyword_id_next         = (text_byte == "t") ? KW_TRUE :
                                          (text_byte == "f") ? KW_FALSE : KW_NULL;
                match_position_next     = 3'd1;
                token_start_column_next = column_counter;
              end
              CH_QUOTE: begin
                lex_mode_next           = MODE_STRING;
                token_start_column_next = column_counter;
                tok_len_next            = FIELD_BITS'(1);
              end
              default: begin
                if ((text_byte == CH_MINUS) || is_digit) begin
                  lex_mode_next           = MODE_NUMBER;
                  token_start_column_next = column_counter;
                  tok_len_next            = FIELD_BITS'(1);
                end else begin
                  e1_v               = 1'b1;
                  e1.kind            = KIND_ERROR;
                  e1.err             = ERR_UNEXPECTED;
                  error_latched_next = 1'b1;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

  // Pack the results into the lowest slots and mark the final one.
  always_comb begin
    res0      = e0_v ? e0 : e1;
    res1      = e1;
    res_count = {1'b0, e0_v} + {1'b0, e1_v};
    if (res_count == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  // State registers advance only when a byte is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode           <= MODE_IDLE;
      keyword_id         <= KW_TRUE;
      match_position     <= '0;
      token_start_column <= '0;
      line_counter       <= '0;
      column_counter     <= '0;
      error_latched      <= 1'b0;
      tok_len            <= '0;
    end else if (fire) begin
      lex_mode           <= lex_mode_next;
      keyword_id         <= keyword_id_next;
      match_position     <= match_position_next;
      token_start_column <= token_start_column_next;
      line_counter       <= line_counter_next;
      column_counter     <= column_counter_next;
      error_latched      <= error_latched_next;
      tok_len            <= tok_len_next;
    end
  end

endmodule

FILE: rtl/jbt_result_queue.sv
// Small result queue that takes up to two results a cycle and gives one.
// Depends on jbt_pkg for the result type and depth.
module jbt_result_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  jbt_pkg::jbt_result_t push0,
  input  jbt_pkg::jbt_result_t push1,
  input  logic                pop,
  output jbt_pkg::jbt_result_t head,
  output logic                not_empty,
  output logic                room2
);
  import jbt_pkg::*;

  jbt_result_t               entries [RES_DEPTH];
  logic [RES_PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [RES_PTR_BITS:0]     count, count_next;
  logic [RES_PTR_BITS-1:0]   wr_ptr_plus;
  logic                      do_pop;

  assign not_empty   = (count != '0);
  assign room2       = (count <= (RES_PTR_BITS+1)'(RES_DEPTH - 2));
  assign head        = entries[rd_ptr];
  assign do_pop      = pop && not_empty;
  assign wr_ptr_plus = wr_ptr + 1'b1;
  assign count_next  = count + (RES_PTR_BITS+1)'(push_count) - (RES_PTR_BITS+1)'(do_pop);

  // Storage: first result at the write pointer, second right after it.
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_plus] <= push1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_BITS'(push_count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

endmodule

FILE: rtl/json_byte_tokenizer.sv
// Top level of the streaming JSON tokenizer: input register, lexer, result queue.
// Depends on jbt_pkg, jbt_text_if, jbt_token_if, jbt_lexer and jbt_result_queue.
//
//   Channel | Dir | Payload                                           | Handshake
//   --------+-----+---------------------------------------------------+-------------
//   text    | in  | text_byte, end_of_document                        | valid/ready
//   tokens  | out | token_kind, start_line, start_column,             | valid/ready
//           |     | token_length, error_code, last_of_run             |
//
// One byte is taken per cycle while ready is high. A byte is held in the input register
// and lexed from there; its results go into the result queue, whose head drives tokens.
// The lexer consumes a byte only when the four-entry queue has room for two results;
// it drains one result per cycle while tokens are taken, which sets the sustained rate.
// Synchronous reset returns all lexer state to idle at once; there is no clearing pass.
// A stalled output fills the queue, then the input register holds and ready falls.
module json_byte_tokenizer (
  input  logic        clk,
  input  logic        rst,
  jbt_text_if.sink    text,
  jbt_token_if.source tokens
);
  import jbt_pkg::*;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_eod;
  logic         fire;
  logic         room2;
  logic         not_empty;
  logic [1:0]   res_count;
  logic [1:0]   push_count;
  jbt_result_t  res0, res1, head;

  // The lexer consumes the registered byte when the queue can absorb its results.
  assign fire       = in_valid && room2;
  assign push_count = fire ? res_count : 2'd0;
  assign text.ready = !in_valid || fire;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      in_byte <= text.text_byte;
      in_eod  <= text.end_of_document;
    end
  end

  jbt_lexer u_lexer (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .text_byte       (in_byte),
    .end_of_document (in_eod),
    .res0            (res0),
    .res1            (res1),
    .res_count       (res_count)
  );

  jbt_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .pop        (tokens.ready),
    .head       (head),
    .not_empty  (not_empty),
    .room2      (room2)
  );

  // Result channel driven from the queue head.
  assign tokens.valid        = not_empty;
  assign tokens.token_kind   = head.kind;
  assign tokens.start_line   = head.line;
  assign tokens.start_column = head.column;
  assign tokens.token_length = head.length;
  assign tokens.error_code   = head.err;
  assign tokens.last_of_run  = head.last;

endmodule

FILE: rtl/jbt_checker.sv
// Port-level checks for the JSON tokenizer, attached to the top level by bind.
// Depends on jbt_pkg for the token kind codes.
module jbt_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_eod,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_kind,
  input logic        out_last,
  input logic [54:0] out_payload
);
  import jbt_pkg::*;

  logic       in_acc, out_acc;
  logic       err_seen;
  logic [3:0] eod_pending;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track whether an error was delivered in this document, and how many
  // end-of-document requests still owe an END result.
  always_ff @(posedge clk) begin
    if (rst) begin
      err_seen    <= 1'b0;
      eod_pending <= '0;
    end else begin
      if (out_acc && (out_kind == KIND_ERROR)) begin
        err_seen <= 1'b1;
      end else if (out_acc && (out_kind == KIND_END)) begin
        err_seen <= 1'b0;
      end
      eod_pending <= eod_pending + 4'(in_acc && in_eod) - 4'(out_acc && (out_kind == KIND_END));
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result changed while stalled");

  // After an error, the only result until the next document is END.
  a_sticky_error: assert property (@(posedge clk) disable iff (rst)
    out_acc && err_seen |-> out_kind == KIND_END)
    else $error("result delivered after an error");

  // Every END answers an end-of-document request.
  a_end_owed: assert property (@(posedge clk) disable iff (rst)
    out_acc && (out_kind == KIND_END) |-> eod_pending != 4'd0)
    else $error("END without end-of-document request");

  // END always closes the run of its request.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_acc && (out_kind == KIND_END) |-> out_last)
    else $error("END not marked last of run");

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (text.valid),
  .in_ready    (text.ready),
  .in_eod      (text.end_of_document),
  .out_valid   (tokens.valid),
  .out_ready   (tokens.ready),
  .out_kind    (tokens.token_kind),
  .out_last    (tokens.last_of_run),
  .out_payload ({tokens.token_kind, tokens.start_line, tokens.start_column,
                 tokens.token_length, tokens.error_code, tokens.last_of_run})
);

FILE: test/tb_json_byte_tokenizer.sv
`timescale 1ns / 100ps
// Self-checking testbench for json_byte_tokenizer: directed table, pressure and random documents.
// Depends on jbt_pkg, jbt_text_if, jbt_token_if and the json_byte_tokenizer RTL.
module tb_json_byte_tokenizer;
  import jbt_pkg::*;

  localparam logic [7:0] TAB       = 8'h09;
  localparam logic [7:0] NEWLINE   = 8'h0A;
  localparam logic [7:0] CR        = 8'h0D;
  localparam logic [7:0] QUOTE     = 8'h22;
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam logic [15:0] SAT16    = 16'hFFFF;
  localparam int RANDOM_REQUESTS   = 350;

  // One row of the directed table; typed rows carry their single expected token.
  typedef struct {
    logic [7:0]  text;
    logic        eod;
    bit          typed;
    jbt_result_t tok;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;

  jbt_text_if  text_bus ();
  jbt_token_if token_bus ();

  json_byte_tokenizer i_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_bus),
    .tokens (token_bus)
  );

  always #1 clk = ~clk;

  // Lexer state as the predictor sees it.
  lex_mode_t   mode;
  keyword_t    kw;
  logic [2:0]  kw_pos;
  logic [15:0] tok_col;
  logic [15:0] tok_len;
  logic [15:0] line_cnt;
  logic [15:0] col_cnt;
  logic        err_seen;
  string       kw_text [3] = '{"true", "false", "null"};

  jbt_result_t step_out [$];
  jbt_result_t tokens_due [$];
  int          token_faults = 0;
  int          useful_sent = 0;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;
  int          outlet_hold = 0;
  dir_row_t    dir_rows [25];

  function automatic void clear_lexer();
    mode     = MODE_IDLE;
    kw       = KW_TRUE;
    kw_pos   = '0;
    tok_col  = '0;
    tok_len  = '0;
    line_cnt = '0;
    col_cnt  = '0;
    err_seen = 1'b0;
  endfunction

  function automatic void emit_tok(token_kind_t k, logic [15:0] l, logic [15:0] c,
                                   logic [15:0] n, error_code_t e);
    jbt_result_t t;
    t.kind   = k;
    t.line   = l;
    t.column = c;
    t.length = n;
    t.err    = e;
    t.last   = 1'b0;
    step_out = {step_out, t};
  endfunction

  function automatic void bump_len();
    if (tok_len != SAT16) tok_len++;
  endfunction

  // A line end closes a number, and turns an open string or keyword into an error.
  function automatic void close_line_tokens();
    case (mode)
      MODE_NUMBER: emit_tok(KIND_NUMBER, line_cnt, tok_col, tok_len, ERR_NONE);
      MODE_STRING, MODE_ESCAPE: begin
        emit_tok(KIND_ERROR, line_cnt, col_cnt, tok_len, ERR_UNTERMINATED);
        err_seen = 1'b1;
      end
      MODE_KEYWORD: begin
        emit_tok(KIND_ERROR, line_cnt, tok_col, 16'd1, ERR_UNEXPECTED);
        err_seen = 1'b1;
      end
      default: ;
    endcase
    mode = MODE_IDLE;
  endfunction

  // Lex a byte that arrives with no token in progress.
  function automatic void start_token(logic [7:0] b);
    case (b)
      " ", TAB, CR: ;
      "{": emit_tok(KIND_LBRACE, line_cnt, col_cnt, 16'd1, ERR_NONE);
      "}": emit_tok(KIND_RBRACE, line_cnt, col_cnt, 16'd1, ERR_NONE);
      "[": emit_tok(KIND_LBRACKET, line_cnt, col_cnt, 16'd1, ERR_NONE);
      "]": emit_tok(KIND_RBRACKET, line_cnt, col_cnt, 16'd1, ERR_NONE);
      ":": emit_tok(KIND_COLON, line_cnt, col_cnt, 16'd1, ERR_NONE);
      ",": emit_tok(KIND_COMMA, line_cnt, col_cnt, 16'd1, ERR_NONE);
      "t", "f", "n": begin
        mode = MODE_KEYWORD;
        if (b == "t") kw = KW_TRUE;
        else if (b == "f") kw = KW_FALSE;
        else kw = KW_NULL;
        kw_pos  = 3'd1;
        tok_col = col_cnt;
      end
      QUOTE: begin
        mode    = MODE_STRING;
        tok_col = col_cnt;
        tok_len = 16'd1;
      end
      default: begin
        if (b == "-" || (b >= "0" && b <= "9")) begin
          mode    = MODE_NUMBER;
          tok_col = col_cnt;
          tok_len = 16'd1;
        end else begin
          err_seen = 1'b1;
          emit_tok(KIND_ERROR, line_cnt, col_cnt, 16'd1, ERR_UNEXPECTED);
        end
      end
    endcase
  endfunction

  // Work out the tokens that one request causes and advance the lexer state.
  function automatic void lex_byte(logic [7:0] b, logic eod);
    int kw_len;
    step_out.delete();
    if (eod) begin
      if (!err_seen) close_line_tokens();
      emit_tok(KIND_END, (line_cnt == SAT16) ? line_cnt : line_cnt + 16'd1, 16'd0, 16'd0,
               ERR_NONE);
      clear_lexer();
    end else if (err_seen) begin
      // Everything up to the end of the document is dropped.
    end else if (b == NEWLINE) begin
      close_line_tokens();
      if (line_cnt != SAT16) line_cnt++;
      col_cnt = '0;
    end else begin
      case (mode)
        MODE_KEYWORD: begin
          kw_len = kw_text[kw].len();
          if (int'(kw_pos) < kw_len && kw_text[kw][kw_pos] == b) begin
            kw_pos++;
            if (int'(kw_pos) >= kw_len) begin
              emit_tok(token_kind_t'(int'(KIND_TRUE) + int'(kw)), line_cnt, tok_col,
                       16'(kw_len), ERR_NONE);
              mode   = MODE_IDLE;
              kw_pos = '0;
            end
          end else begin
            emit_tok(KIND_ERROR, line_cnt, tok_col, 16'd1, ERR_UNEXPECTED);
            err_seen = 1'b1;
            mode     = MODE_IDLE;
            kw_pos   = '0;
          end
        end
        MODE_STRING: begin
          bump_len();
          if (b == BACKSLASH) begin
            mode = MODE_ESCAPE;
          end else if (b == QUOTE) begin
            emit_tok(KIND_STRING, line_cnt, tok_col, tok_len, ERR_NONE);
            mode = MODE_IDLE;
          end
        end
        MODE_ESCAPE: begin
          bump_len();
          mode = MODE_STRING;
        end
        default: begin
          if (mode == MODE_NUMBER && b >= "0" && b <= "9") begin
            bump_len();
          end else begin
            // A non-digit ends a number and is then lexed on its own.
            if (mode == MODE_NUMBER)
              emit_tok(KIND_NUMBER, line_cnt, tok_col, tok_len, ERR_NONE);
            mode = MODE_IDLE;
            start_token(b);
          end
        end
      endcase
      if (col_cnt != SAT16) col_cnt++;
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
  endfunction

  function automatic dir_row_t free_row(logic [7:0] b, logic eod);
    dir_row_t r;
    r.text  = b;
    r.eod   = eod;
    r.typed = 1'b0;
    r.tok   = '0;
    return r;
  endfunction

  function automatic dir_row_t fixed_row(logic [7:0] b, logic eod, token_kind_t k,
                                         int l, int c, int n, error_code_t e);
    dir_row_t r;
    r.text       = b;
    r.eod        = eod;
    r.typed      = 1'b1;
    r.tok.kind   = k;
    r.tok.line   = 16'(l);
    r.tok.column = 16'(c);
    r.tok.length = 16'(n);
    r.tok.err    = e;
    r.tok.last   = 1'b1;
    return r;
  endfunction

  // Offer one request, after a random gap if the sender idles, and hold it until it is accepted.
  task automatic drive_req(input logic [7:0] b, input logic eod);
    int gap;
    gap = sender_idles ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      text_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_bus.valid           <= 1'b1;
    text_bus.text_byte       <= b;
    text_bus.end_of_document <= eod;
    do @(posedge clk); while (!text_bus.ready);
  endtask

  task automatic send_req(input logic [7:0] b, input logic eod);
    if (!err_seen || eod) useful_sent++;
    lex_byte(b, eod);
    tokens_due = {tokens_due, step_out};
    drive_req(b, eod);
  endtask

  task automatic send_keyword();
    int    id;
    int    cut;
    string word;
    id   = $urandom_range(0, 2);
    word = kw_text[id];
    // Now and then a keyword is broken off by a stray byte.
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, word.len() - 1) : word.len();
    for (int i = 0; i < cut; i++) send_req(word[i], 1'b0);
    if (cut < word.len()) send_req($urandom_range(0, 9) == 0 ? NEWLINE : 8'($urandom), 1'b0);
  endtask

  task automatic send_string();
    int         n;
    logic [7:0] c;
    send_req(QUOTE, 1'b0);
    n = $urandom_range(0, 8);
    repeat (n) begin
      if ($urandom_range(0, 6) == 0) begin
        send_req(BACKSLASH, 1'b0);
        case ($urandom_range(0, 3))
          0:       c = QUOTE;
          1:       c = BACKSLASH;
          2:       c = "n";
          default: c = 8'($urandom);
        endcase
      end else begin
        c = 8'($urandom);
        if (c == QUOTE || c == BACKSLASH || c == NEWLINE) c = "a";
      end
      send_req(c, 1'b0);
    end
    if ($urandom_range(0, 19) != 0) send_req(QUOTE, 1'b0);
  endtask

  task automatic send_number();
    int digits;
    bit neg;
    neg = $urandom_range(0, 1);
    if (neg) send_req("-", 1'b0);
    digits = $urandom_range(neg ? 0 : 1, 5);
    repeat (digits) send_req(8'("0" + $urandom_range(0, 9)), 1'b0);
  endtask

  // A random document of mostly well-formed tokens, closed by end of document.
  task automatic send_document();
    int    pick;
    int    count;
    string punct;
    punct          = "{}[]:,";
    sender_idles   = ($urandom_range(0, 3) != 0);
    receiver_idles = ($urandom_range(0, 3) != 0);
    count          = $urandom_range(1, 15);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) send_req(punct[$urandom_range(0, 5)], 1'b0);
      else if (pick < 35) send_keyword();
      else if (pick < 55) send_string();
      else if (pick < 70) send_number();
      else if (pick < 82) begin
        case ($urandom_range(0, 2))
          0:       send_req(" ", 1'b0);
          1:       send_req(TAB, 1'b0);
          default: send_req(CR, 1'b0);
        endcase
      end else if (pick < 95) send_req(NEWLINE, 1'b0);
      else send_req(8'($urandom), 1'b0);
    end
    send_req(8'($urandom), 1'b1);
  endtask

  // Token side: random stalls, a single long hold-off, and checking.
  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      token_faults++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  initial begin
    int          gap;
    jbt_result_t want;
    token_bus.ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (outlet_hold > 0) begin
        token_bus.ready <= 1'b0;
        repeat (outlet_hold) @(posedge clk);
        outlet_hold = 0;
      end
      gap = receiver_idles ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        token_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      token_bus.ready <= 1'b1;
      do @(posedge clk); while (!token_bus.valid);
      if (tokens_due.size() == 0) begin
        token_faults++;
        $display("%0t: no token expected, got kind %0d line %0d column %0d", $time,
                 token_bus.token_kind, token_bus.start_line, token_bus.start_column);
      end else begin
        want = tokens_due.pop_front();
        compare_field("token_kind", want.kind, token_bus.token_kind);
        compare_field("start_line", want.line, token_bus.start_line);
        compare_field("start_column", want.column, token_bus.start_column);
        compare_field("token_length", want.length, token_bus.token_length);
        compare_field("error_code", want.err, token_bus.error_code);
        compare_field("last_of_run", want.last, token_bus.last_of_run);
      end
    end
  end

  // Text side and the run itself.
  initial begin
    rst                      = 1'b1;
    text_bus.valid           = 1'b0;
    text_bus.text_byte       = 8'h00;
    text_bus.end_of_document = 1'b0;
    clear_lexer();

    // Punctuation, skipped bytes, number closed by newline, escapes, byte extremes,
    // broken keyword, open string at line end, sticky errors and an empty document.
    dir_rows = '{
      fixed_row("{", 1'b0, KIND_LBRACE, 0, 0, 1, ERR_NONE),
      free_row("}", 1'b0), free_row("[", 1'b0), free_row("]", 1'b0),
      free_row(":", 1'b0), free_row(",", 1'b0), free_row(TAB, 1'b0),
      free_row("-", 1'b0), free_row("9", 1'b0), free_row(NEWLINE, 1'b0),
      free_row(QUOTE, 1'b0), free_row(BACKSLASH, 1'b0), free_row(8'hFF, 1'b0),
      free_row(QUOTE, 1'b0),
      fixed_row(8'h00, 1'b0, KIND_ERROR, 1, 4, 1, ERR_UNEXPECTED),
      fixed_row(8'hFF, 1'b1, KIND_END, 2, 0, 0, ERR_NONE),
      free_row("f", 1'b0), free_row("a", 1'b0),
      fixed_row("x", 1'b0, KIND_ERROR, 0, 0, 1, ERR_UNEXPECTED),
      fixed_row(QUOTE, 1'b1, KIND_END, 1, 0, 0, ERR_NONE),
      free_row(QUOTE, 1'b0), free_row(BACKSLASH, 1'b0),
      fixed_row(NEWLINE, 1'b0, KIND_ERROR, 0, 2, 2, ERR_UNTERMINATED),
      fixed_row(8'h00, 1'b1, KIND_END, 2, 0, 0, ERR_NONE),
      fixed_row(NEWLINE, 1'b1, KIND_END, 1, 0, 0, ERR_NONE)
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        lex_byte(dir_rows[i].text, dir_rows[i].eod);
        tokens_due = {tokens_due, dir_rows[i].tok};
        drive_req(dir_rows[i].text, dir_rows[i].eod);
      end else begin
        send_req(dir_rows[i].text, dir_rows[i].eod);
      end
    end

    // Long hold-off on the token side while brackets keep coming, so the block backs up.
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    outlet_hold    = 150;
    repeat (24) send_req("[", 1'b0);
    send_req(8'h00, 1'b1);

    useful_sent = 0;
    while (useful_sent < RANDOM_REQUESTS) send_document();
    text_bus.valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (token_faults == 0 && tokens_due.size() == 0) begin
      $display("tb_json_byte_tokenizer passed");
    end else begin
      $display("tb_json_byte_tokenizer failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4000000;
    $display("tb_json_byte_tokenizer failed");
    $finish;
  end

endmodule

FILE: sim.f
rtl/jbt_pkg.sv
rtl/jbt_text_if.sv
rtl/jbt_token_if.sv
rtl/jbt_lexer.sv
rtl/jbt_result_queue.sv
rtl/json_byte_tokenizer.sv
rtl/jbt_checker.sv
test/tb_json_byte_tokenizer.sv
